// ===== hdl/cnra_pkg.sv =====
// Shared constants, codes and interface types of the refractory node automaton.
`timescale 1ns / 1ps

package cnra_pkg;

    localparam int TIMER_BITS = 12;
    localparam int Q_BITS     = 16;
    localparam int RATIO_W    = Q_BITS + 1;
    localparam int SQ_W       = 2 * Q_BITS + 1;
    localparam int MUL_A_W    = 3 * Q_BITS + 1;
    localparam int MUL_B_W    = RATIO_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W  = $clog2(MUL_B_W);
    localparam int DIV_CNT_W  = $clog2(Q_BITS);
    localparam int SCALE_W    = 11;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << Q_BITS;
    localparam logic [MUL_A_W-1:0] CUBE_ONE  = MUL_A_W'(1) << (3 * Q_BITS);
    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(256);
    localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(1024);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ERP_MIN     = 3'd0,
        CFG_ERP_MAX     = 3'd1,
        CFG_REST_LENGTH = 3'd2,
        CFG_RRP_LENGTH  = 3'd3,
        CFG_AV_NODE     = 3'd4
    } t_cfg_addr;

    typedef enum logic [1:0] {
        PH_REST = 2'd0,
        PH_ERP  = 2'd1,
        PH_RRP  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQR,
        ST_CUBE,
        ST_BLEND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [TIMER_BITS-1:0] num;
        logic [TIMER_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [RATIO_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } t_mul_rsp;

endpackage

// ===== hdl/cnra_div.sv =====
// Restoring radix-2 divider: timer over length as a Q1.16 ratio, saturated at 1.0.
`timescale 1ns / 1ps

module cnra_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cnra_pkg::t_div_req i_req,
    output cnra_pkg::t_div_rsp o_rsp
);
    import cnra_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic                  r_sat, n_sat;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [TIMER_BITS:0]   r_rem, n_rem;
    logic [Q_BITS-1:0]     r_quo, n_quo;
    logic [TIMER_BITS:0]   rem2;
    logic                  ge;

    always_comb begin
        rem2   = {r_rem[TIMER_BITS-1:0], 1'b0};
        ge     = rem2 >= {1'b0, i_req.den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_req.start) begin
            if (i_req.den == '0 || i_req.num >= i_req.den) begin
                n_sat  = 1'b1;
                n_done = 1'b1;
            end else begin
                n_sat  = 1'b0;
                n_busy = 1'b1;
                n_cnt  = '0;
                n_rem  = {1'b0, i_req.num};
            end
        end else if (r_busy) begin
            // rem stays below den, so the doubled value never overflows
            n_rem = ge ? rem2 - {1'b0, i_req.den} : rem2;
            n_quo = {r_quo[Q_BITS-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(Q_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat <= n_sat;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sat ? RATIO_ONE : {1'b0, r_quo};

endmodule

// ===== hdl/cnra_mul.sv =====
// Shift-add serial multiplier, one multiplier bit per cycle, shared by all products.
`timescale 1ns / 1ps

module cnra_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cnra_pkg::t_mul_req i_req,
    output cnra_pkg::t_mul_rsp o_rsp
);
    import cnra_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic [MUL_A_W-1:0]   r_a, n_a;
    logic [MUL_P_W-1:0]   r_acc, n_acc;
    logic [MUL_A_W:0]     sum;

    always_comb begin
        // upper MUL_A_W bits accumulate, multiplier bits drain out of the low end
        sum    = {1'b0, r_acc[MUL_P_W-1:MUL_B_W]} + (r_acc[0] ? {1'b0, r_a} : '0);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_req.a;
            n_acc  = {{MUL_A_W{1'b0}}, i_req.b};
        end else if (r_busy) begin
            n_acc = {sum, r_acc[MUL_B_W-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_acc <= n_acc;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

// ===== hdl/cardiac_node_refractory_automaton.sv =====
// Top level of the refractory node automaton: phase sequencer, timers and output register.
//
//   channel   dir  handshake                       payload
//   s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tick with activation flag
//   m_axis    out  o_m_axis_tvalid/i_m_axis_tready  one result per tick
//   cfg       in   i_cfg_we                         register index and write data
//
// Ordinary ticks are taken whenever the sequencer is idle and the output register is free.
// A firing from relative refractory holds off the next transfer while the serial divider forms
// the ratio and the shift-add multiplier makes three passes (square, cube, blend); the
// divider answers at once when the ratio saturates. Reset is synchronous, active low, and
// clears all phase state.
// A stalled output holds its transfer; the next tick waits until it is taken.
`timescale 1ns / 1ps

module cardiac_node_refractory_automaton (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [cnra_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // [0] activated
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] activate_paths, [1] rescale_paths, [12:2] path_scale, [14:13] phase_now,
    // [26:15] erp_now
    output logic [cnra_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [cnra_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [cnra_pkg::TIMER_BITS-1:0]     i_cfg_wdata
);
    import cnra_pkg::*;

    // configuration
    logic [TIMER_BITS-1:0] r_erp_min, r_erp_max, r_rest_length, r_rrp_length;
    logic                  r_av_node;

    // node state
    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_erp_timer, n_erp_timer;
    logic [TIMER_BITS-1:0] r_erp_default, n_erp_default;
    logic [TIMER_BITS-1:0] r_rrp_timer, n_rrp_timer;
    logic [TIMER_BITS-1:0] r_rest_timer, n_rest_timer;

    // work registers of a restitution update
    logic [RATIO_W-1:0]    r_x, n_x;
    logic [SCALE_W-1:0]    r_scale, n_scale;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_o_act, n_o_act;
    logic                  r_o_resc, n_o_resc;
    logic [SCALE_W-1:0]    r_o_scale, n_o_scale;
    t_phase                r_o_phase, n_o_phase;
    logic [TIMER_BITS-1:0] r_o_erp, n_o_erp;

    t_div_req              div_req;
    t_div_rsp              div_rsp;
    t_mul_req              mul_req;
    t_mul_rsp              mul_rsp;

    logic                  acc_in, out_free, activated, fire_rrp;
    logic [TIMER_BITS-1:0] base, other, erp_span, cpart, erp_new;
    logic                  up, frac_nz;
    logic [RATIO_W-1:0]    x_new;
    logic [RATIO_W+1:0]    av_sum;
    logic [SQ_W-1:0]       sq;
    logic [SQ_W+1:0]       sq_sum;
    logic [SCALE_W-1:0]    av_scale, plain_scale;

    cnra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    cnra_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign acc_in          = i_s_axis_tvalid && o_s_axis_tready;
    assign activated       = i_s_axis_tdata[0];
    assign fire_rrp        = activated && (r_phase == PH_RRP);

    // AV curve blends from erp_max toward erp_min, plain curve the other way
    assign base     = r_av_node ? r_erp_max : r_erp_min;
    assign other    = r_av_node ? r_erp_min : r_erp_max;
    assign up       = other >= base;
    assign erp_span = up ? other - base : base - other;

    assign x_new    = r_av_node ? RATIO_ONE - div_rsp.quot : div_rsp.quot;
    assign av_sum   = {1'b0, div_rsp.quot, 1'b0} + {2'b0, div_rsp.quot}
                    + ((RATIO_W + 2)'(1) << (Q_BITS - 9));
    assign av_scale = SCALE_ONE + SCALE_W'(av_sum >> (Q_BITS - 8));

    assign sq          = mul_rsp.prod[SQ_W-1:0];
    assign sq_sum      = {1'b0, sq, 1'b0} + {2'b0, sq} + ((SQ_W + 2)'(1) << (2 * Q_BITS - 9));
    assign plain_scale = SCALE_ONE + SCALE_W'(sq_sum >> (2 * Q_BITS - 8));

    // blend product: integer part above 48 fraction bits, ceiling when moving down
    assign cpart   = mul_rsp.prod[3 * Q_BITS +: TIMER_BITS];
    assign frac_nz = |mul_rsp.prod[3 * Q_BITS - 1:0];
    assign erp_new = up ? base + cpart : base - (cpart + TIMER_BITS'(frac_nz));

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_erp_timer   = r_erp_timer;
        n_erp_default = r_erp_default;
        n_rrp_timer   = r_rrp_timer;
        n_rest_timer  = r_rest_timer;
        n_x           = r_x;
        n_scale       = r_scale;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_o_act       = r_o_act;
        n_o_resc      = r_o_resc;
        n_o_scale     = r_o_scale;
        n_o_phase     = r_o_phase;
        n_o_erp       = r_o_erp;
        div_req.start = 1'b0;
        div_req.num   = r_rrp_timer;
        div_req.den   = r_rrp_length;
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (acc_in) begin
                    n_o_act   = 1'b0;
                    n_o_resc  = 1'b0;
                    n_o_scale = SCALE_ONE;
                    if (activated) begin
                        unique case (r_phase)
                            PH_REST: begin
                                n_o_act       = 1'b1;
                                n_o_resc      = 1'b1;
                                n_erp_default = r_erp_max;
                                n_erp_timer   = r_erp_max;
                                n_rest_timer  = r_rest_length;
                                n_phase       = PH_ERP;
                            end
                            PH_ERP: begin
                                n_erp_default = r_erp_min;
                                n_erp_timer   = r_erp_min;
                            end
                            PH_RRP: begin
                                div_req.start = 1'b1;
                                n_rrp_timer   = r_rrp_length;
                                n_phase       = PH_ERP;
                                n_state       = ST_DIV;
                            end
                            default: ;
                        endcase
                    end else begin
                        unique case (r_phase)
                            PH_REST: begin
                                if (r_rest_timer != '0) begin
                                    n_rest_timer = r_rest_timer - 1'b1;
                                end else begin
                                    n_phase      = PH_ERP;
                                    n_rest_timer = r_rest_length;
                                    n_o_act      = 1'b1;
                                end
                            end
                            PH_ERP: begin
                                if (r_erp_timer != '0) begin
                                    n_erp_timer = r_erp_timer - 1'b1;
                                end else begin
                                    n_phase     = PH_RRP;
                                    n_erp_timer = r_erp_default;
                                end
                            end
                            PH_RRP: begin
                                if (r_rrp_timer != '0) begin
                                    n_rrp_timer = r_rrp_timer - 1'b1;
                                end else begin
                                    n_phase     = PH_REST;
                                    n_rrp_timer = r_rrp_length;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (!fire_rrp) begin
                        n_out_valid = 1'b1;
                        n_o_phase   = n_phase;
                        n_o_erp     = n_erp_default;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_x           = x_new;
                    n_scale       = r_av_node ? av_scale : r_scale;
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(x_new);
                    mul_req.b     = x_new;
                    n_state       = ST_SQR;
                end
            end
            ST_SQR: begin
                if (mul_rsp.done) begin
                    if (!r_av_node) begin
                        n_scale = plain_scale;
                    end
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(sq);
                    mul_req.b     = r_x;
                    n_state       = ST_CUBE;
                end
            end
            ST_CUBE: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = CUBE_ONE - mul_rsp.prod[MUL_A_W-1:0];
                    mul_req.b     = MUL_B_W'(erp_span);
                    n_state       = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (mul_rsp.done) begin
                    n_erp_default = erp_new;
                    n_erp_timer   = erp_new;
                    n_state       = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_act     = 1'b1;
                    n_o_resc    = 1'b1;
                    n_o_scale   = r_scale;
                    n_o_phase   = r_phase;
                    n_o_erp     = r_erp_default;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= PH_REST;
            r_erp_timer   <= '0;
            r_erp_default <= '0;
            r_rrp_timer   <= '0;
            r_rest_timer  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_erp_timer   <= n_erp_timer;
            r_erp_default <= n_erp_default;
            r_rrp_timer   <= n_rrp_timer;
            r_rest_timer  <= n_rest_timer;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_scale   <= n_scale;
        r_o_act   <= n_o_act;
        r_o_resc  <= n_o_resc;
        r_o_scale <= n_o_scale;
        r_o_phase <= n_o_phase;
        r_o_erp   <= n_o_erp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erp_min     <= '0;
            r_erp_max     <= '0;
            r_rest_length <= '0;
            r_rrp_length  <= TIMER_BITS'(1);
            r_av_node     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ERP_MIN:     r_erp_min     <= i_cfg_wdata;
                CFG_ERP_MAX:     r_erp_max     <= i_cfg_wdata;
                CFG_REST_LENGTH: r_rest_length <= i_cfg_wdata;
                CFG_RRP_LENGTH:  r_rrp_length  <= i_cfg_wdata;
                CFG_AV_NODE:     r_av_node     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_o_erp, r_o_phase, r_o_scale, r_o_resc, r_o_act});

    // a firing from relative refractory must start the ratio division
    a_rrp_fire_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && fire_rrp) |=> (r_state == ST_DIV))
        else $error("relative refractory firing did not start the divider");

    // the finished update lands in the output register as a firing into ERP
    a_update_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=>
        (r_out_valid && r_o_act && r_o_resc && r_o_phase == PH_ERP))
        else $error("restitution result not delivered as a firing");

    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_scale >= SCALE_ONE && r_o_scale <= SCALE_MAX))
        else $error("path scale out of range");

    a_rescale_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_resc) |-> r_o_act)
        else $error("rescale without firing");

endmodule
